// ----- design/trb_pkg.sv -----
`default_nettype none

package trb_pkg;

	// Pixel and configuration widths.
	localparam int PIX_W = 8;
	localparam int DIM_REG_W = 13;
	localparam int POS_W = 12;
	localparam int IN_DATA_W = 2 * PIX_W + 2 * POS_W;

	// Default largest image dimension handled by the ramps.
	localparam int MAX_DIM_DEFAULT = 4096;

	// Ramp pipeline shape: one product stage, the divider stages, one rounding stage.
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = PIX_W / DIV_STEPS_PER_STAGE;
	localparam int RAMP_STAGES = DIV_STAGES + 2;

	// Whole block: selection stage, ramp stages, averaging stage.
	localparam int PIPE_STAGES = RAMP_STAGES + 2;

	// Configuration register map.
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEFT_SOURCE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT_SOURCE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TOP_SOURCE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM_SOURCE = 3'd5;

	localparam logic [DIM_REG_W-1:0] RESET_IMAGE_WIDTH = 13'd640;
	localparam logic [DIM_REG_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;

endpackage

`default_nettype wire

// ----- design/trb_ramp.sv -----
`default_nettype none

module trb_ramp import trb_pkg::*; #(
	parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic [RAMP_STAGES-1:0] advance,
	input  wire logic [PIX_W-1:0]       near_px,
	input  wire logic [PIX_W-1:0]       far_px,
	input  wire logic [$clog2(MAX_DIMENSION)-1:0] pos,
	input  wire logic [$clog2(MAX_DIMENSION)-1:0] den,
	output logic [PIX_W-1:0]            ramp_px
);

	localparam int DIM_W = $clog2(MAX_DIMENSION);
	localparam int NUM_W = DIM_W + PIX_W;

	// Index 0 holds the product stage; index j holds divider stage j.
	logic [NUM_W-1:0] rem_s [0:DIV_STAGES];
	logic [PIX_W-1:0] quo_s [0:DIV_STAGES];
	logic [DIM_W-1:0] den_s [0:DIV_STAGES];
	logic [PIX_W-1:0] res_s7;

	logic [NUM_W-1:0] num_d;
	logic [NUM_W-1:0] rem_d [1:DIV_STAGES];
	logic [PIX_W-1:0] quo_d [1:DIV_STAGES];
	logic [PIX_W:0]   rounded;

	// Numerator of the ramp: near * (d - p) + far * p, which stays below 256 * d.
	always_comb begin
		num_d = ({{DIM_W{1'b0}}, near_px} * NUM_W'(den - pos))
			+ ({{DIM_W{1'b0}}, far_px} * NUM_W'(pos));
	end

	// Restoring division, two quotient bits per stage, most significant first.
	always_comb begin
		logic [NUM_W-1:0] r;
		logic [PIX_W-1:0] q;
		logic [NUM_W-1:0] dsh;
		for (int j = 1; j <= DIV_STAGES; j++) begin
			r = rem_s[j-1];
			q = quo_s[j-1];
			for (int t = 0; t < DIV_STEPS_PER_STAGE; t++) begin
				dsh = NUM_W'(den_s[j-1]) << ((PIX_W - 1) - ((j - 1) * DIV_STEPS_PER_STAGE + t));
				if (r >= dsh) begin
					r = r - dsh;
					q = {q[PIX_W-2:0], 1'b1};
				end else begin
					q = {q[PIX_W-2:0], 1'b0};
				end
			end
			rem_d[j] = r;
			quo_d[j] = q;
		end
	end

	// Round half to even: the remainder is below the divisor.
	always_comb begin
		logic [DIM_W:0] twice_rem;
		twice_rem = {rem_s[DIV_STAGES][DIM_W-1:0], 1'b0};
		if (twice_rem > {1'b0, den_s[DIV_STAGES]}
				|| (twice_rem == {1'b0, den_s[DIV_STAGES]} && quo_s[DIV_STAGES][0])) begin
			rounded = {1'b0, quo_s[DIV_STAGES]} + 1'b1;
		end else begin
			rounded = {1'b0, quo_s[DIV_STAGES]};
		end
	end

	// Stage registers, each loaded when its stage advances.
	always_ff @(posedge clk) begin
		if (advance[0]) begin
			rem_s[0] <= num_d;
			quo_s[0] <= '0;
			den_s[0] <= den;
		end
		for (int j = 1; j <= DIV_STAGES; j++) begin
			if (advance[j]) begin
				rem_s[j] <= rem_d[j];
				quo_s[j] <= quo_d[j];
				den_s[j] <= den_s[j-1];
			end
		end
		if (advance[RAMP_STAGES-1]) begin
			res_s7 <= rounded[PIX_W-1:0];
		end
	end

	assign ramp_px = res_s7;

endmodule

`default_nettype wire

// ----- design/two_image_ramp_blend.sv -----
// Each input transfer is registered through the selection, ramp and averaging stages.
// Throughput: one pixel per cycle unless the output stalls; the depth comes from the
// restoring divider of each ramp, with two quotient bits in each of its four stages.
// Every stage holds its item under back pressure and takes a new one once it empties.
// Reset (arst_n low) empties the pipeline and sets width 640, height 480, all sources 0.
`default_nettype none

module two_image_ramp_blend import trb_pkg::*; #(
	parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata, low bit up: pixel_first[7:0], pixel_second[15:8], column[27:16], row[39:28].
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// Output stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata, low bit up: blended_pixel[7:0].
	output logic [PIX_W-1:0]           m_tdata,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int DIM_W = $clog2(MAX_DIMENSION);

	// Configuration registers.
	logic [DIM_REG_W-1:0] width_q;
	logic [DIM_REG_W-1:0] height_q;
	logic                 left_src_q;
	logic                 right_src_q;
	logic                 top_src_q;
	logic                 bottom_src_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_write;

	assign pready = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes at the access cycle of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_IMAGE_WIDTH;
			height_q <= RESET_IMAGE_HEIGHT;
			left_src_q <= 1'b0;
			right_src_q <= 1'b0;
			top_src_q <= 1'b0;
			bottom_src_q <= 1'b0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_IMAGE_WIDTH: width_q <= pwdata[DIM_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_REG_W-1:0];
				REG_LEFT_SOURCE: left_src_q <= pwdata[0];
				REG_RIGHT_SOURCE: right_src_q <= pwdata[0];
				REG_TOP_SOURCE: top_src_q <= pwdata[0];
				REG_BOTTOM_SOURCE: bottom_src_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH: prdata = CFG_DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(height_q);
			REG_LEFT_SOURCE: prdata = CFG_DATA_W'(left_src_q);
			REG_RIGHT_SOURCE: prdata = CFG_DATA_W'(right_src_q);
			REG_TOP_SOURCE: prdata = CFG_DATA_W'(top_src_q);
			REG_BOTTOM_SOURCE: prdata = CFG_DATA_W'(bottom_src_q);
			default: prdata = '0;
		endcase
	end

	// Pipeline occupancy and per-stage flow control.
	logic [PIPE_STAGES:1]   valid_q;
	logic [PIPE_STAGES+1:1] stage_ready;

	always_comb begin
		stage_ready[PIPE_STAGES+1] = m_tready;
		for (int k = PIPE_STAGES; k >= 1; k--) begin
			stage_ready[k] = !valid_q[k] || stage_ready[k+1];
		end
	end

	assign s_tready = stage_ready[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (stage_ready[1]) begin
				valid_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= PIPE_STAGES; k++) begin
				if (stage_ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Empty-pixel filling and edge source selection.
	logic [PIX_W-1:0] px_a;
	logic [PIX_W-1:0] px_b;
	logic [PIX_W-1:0] in_first;
	logic [PIX_W-1:0] in_second;
	logic [POS_W-1:0] in_column;
	logic [POS_W-1:0] in_row;

	assign in_first = s_tdata[PIX_W-1:0];
	assign in_second = s_tdata[2*PIX_W-1:PIX_W];
	assign in_column = s_tdata[2*PIX_W+POS_W-1:2*PIX_W];
	assign in_row = s_tdata[2*PIX_W+2*POS_W-1:2*PIX_W+POS_W];

	always_comb begin
		px_a = (in_first == '0) ? in_second : in_first;
		px_b = (in_second == '0) ? px_a : in_second;
	end

	// Ramp divisor d = min(dim, max) - 1 and clamped position; tiny dimensions pin to near.
	function automatic logic [2*DIM_W-1:0] ramp_geometry(
		input logic [DIM_REG_W-1:0] dim,
		input logic [POS_W-1:0]     position
	);
		logic [DIM_W-1:0] d;
		logic [DIM_W-1:0] p;
		if (dim < DIM_REG_W'(2)) begin
			d = DIM_W'(1);
			p = '0;
		end else begin
			if (32'(dim) > 32'(MAX_DIMENSION)) begin
				d = DIM_W'(MAX_DIMENSION - 1);
			end else begin
				d = DIM_W'(dim - 1'b1);
			end
			if (32'(position) > 32'(d)) begin
				p = d;
			end else begin
				p = DIM_W'(position);
			end
		end
		return {d, p};
	endfunction

	logic [2*DIM_W-1:0] geom_h;
	logic [2*DIM_W-1:0] geom_v;

	assign geom_h = ramp_geometry(width_q, in_column);
	assign geom_v = ramp_geometry(height_q, in_row);

	// Stage 1: selected edge pixels and ramp geometry.
	logic [PIX_W-1:0] near_h_s1;
	logic [PIX_W-1:0] far_h_s1;
	logic [PIX_W-1:0] near_v_s1;
	logic [PIX_W-1:0] far_v_s1;
	logic [DIM_W-1:0] den_h_s1;
	logic [DIM_W-1:0] pos_h_s1;
	logic [DIM_W-1:0] den_v_s1;
	logic [DIM_W-1:0] pos_v_s1;

	always_ff @(posedge clk) begin
		if (stage_ready[1]) begin
			near_h_s1 <= left_src_q ? px_b : px_a;
			far_h_s1 <= right_src_q ? px_b : px_a;
			near_v_s1 <= top_src_q ? px_b : px_a;
			far_v_s1 <= bottom_src_q ? px_b : px_a;
			den_h_s1 <= geom_h[2*DIM_W-1:DIM_W];
			pos_h_s1 <= geom_h[DIM_W-1:0];
			den_v_s1 <= geom_v[2*DIM_W-1:DIM_W];
			pos_v_s1 <= geom_v[DIM_W-1:0];
		end
	end

	// Stages 2 to 7: the two ramps.
	logic [PIX_W-1:0] ramp_h;
	logic [PIX_W-1:0] ramp_v;

	trb_ramp #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_ramp_h (
		.clk(clk),
		.advance(stage_ready[RAMP_STAGES+1:2]),
		.near_px(near_h_s1),
		.far_px(far_h_s1),
		.pos(pos_h_s1),
		.den(den_h_s1),
		.ramp_px(ramp_h)
	);

	trb_ramp #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_ramp_v (
		.clk(clk),
		.advance(stage_ready[RAMP_STAGES+1:2]),
		.near_px(near_v_s1),
		.far_px(far_v_s1),
		.pos(pos_v_s1),
		.den(den_v_s1),
		.ramp_px(ramp_v)
	);

	// Stage 8: average of the two ramps, rounded half to even.
	logic [PIX_W:0]   ramp_sum;
	logic [PIX_W-1:0] avg;
	logic [PIX_W-1:0] out_s8;

	always_comb begin
		ramp_sum = {1'b0, ramp_h} + {1'b0, ramp_v};
		avg = ramp_sum[PIX_W:1];
		if (ramp_sum[0] && avg[0]) begin
			avg = avg + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[PIPE_STAGES]) begin
			out_s8 <= avg;
		end
	end

	assign m_tvalid = valid_q[PIPE_STAGES];
	assign m_tdata = out_s8;

	// The input side is ready exactly when some stage is free or the output drains.
	a_ready_matches_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!(&valid_q) || m_tready))
		else $error("input ready disagrees with pipeline occupancy");

	// An item held in a stalled first stage is not dropped.
	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[1] && !stage_ready[1] |=> valid_q[1])
		else $error("stalled item lost in first stage");

	// A delivered result is not shown again unless a new one follows it.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !valid_q[PIPE_STAGES-1] |=> !m_tvalid)
		else $error("result repeated on output");

endmodule

`default_nettype wire
